/* hw/rtl/asa_pkg.sv */
// Shared types and codes for the aligned stack allocator.
// Depends on nothing; the allocator and the bench import it.
package asa_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 21;
  localparam int unsigned ALIGN_W   = 4;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] CAPACITY_RESET = 21'h100000;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_NOT_TOP  = 3'd2,
    ST_NULL     = 3'd3,
    ST_FULL     = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE     = 2'd0,
    CFG_CAPACITY = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [SIZE_W-1:0]  request_size;
    logic [ALIGN_W-1:0] align_log2;
    logic [ADDR_W-1:0]  free_address;
  } in_beat_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] user_address;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    value;
  } cfg_beat_t;

endpackage

/* hw/rtl/asa_stream_if.sv */
// Valid/ready channel carrying one beat of payload type T.
// Used for the command, result and configuration channels.
interface asa_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/aligned_stack_allocator.sv */
// LIFO stack allocator with per-allocation alignment.
// An accepted command waits in S_DONE until the result register is free or drained;
// then its result beat is registered. No new command is taken until S_IDLE; S_DONE
// reads the registered top entry of the stack memory and finishes the span check.
// Reset (rst_n low, synchronous): stack empty, used count zero, base 0,
// capacity 1 MiB; stack memory contents are not cleared.
module aligned_stack_allocator #(
  parameter int unsigned MAX_ALLOCS   = 64,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned REGION_BITS  = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  asa_stream_if.sink   in_ch,
  asa_stream_if.source out_ch,
  asa_stream_if.sink   cfg_ch
);

  import asa_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_ALLOCS + 1);
  localparam int unsigned IDX_W  = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
  localparam int unsigned HOFF_W = REGION_BITS;
  localparam int unsigned ENT_W  = HOFF_W + ADDR_W;
  // Address arithmetic width: base + used + header + padding + size never
  // reaches 2^35.
  localparam int unsigned TOT_W  = ADDR_W + 3;

  localparam logic [TOT_W-1:0] REGION_SIZE = TOT_W'(1) << REGION_BITS;
  localparam logic [TOT_W-1:0] HDR_SIZE    = TOT_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(MAX_ALLOCS);

  typedef enum logic {S_IDLE, S_DONE} state_t;

  // Control and configuration state.
  state_t             state_r;
  logic [ADDR_W-1:0]  base_r;
  logic [SIZE_W-1:0]  cap_r;
  logic [SIZE_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  out_beat_t          out_r;

  // Command captured at acceptance.
  cmd_t               cmd_r;
  logic [SIZE_W-1:0]  size_r;
  logic [ADDR_W-1:0]  free_r;
  logic [TOT_W-1:0]   user_r;

  logic               in_acc;
  logic               done_go;
  logic [MASK_W-1:0]  mask_in;
  logic [TOT_W-1:0]   user_in;

  logic [TOT_W-1:0]   eff_cap;
  logic [TOT_W-1:0]   tot;
  logic               no_space;

  logic [ENT_W-1:0]   rd_data;
  logic [HOFF_W-1:0]  top_hoff;
  logic [ADDR_W-1:0]  top_addr;

  status_t            dec_status;
  logic [ADDR_W-1:0]  dec_addr;
  logic               push, pop;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Finish only when the result register is free or being drained.
  assign done_go = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // First half of allocate, done in the accept cycle: round the first byte
  // after the header up to the alignment.
  assign mask_in = MASK_W'((32'd1 << in_ch.data.align_log2) - 32'd1);
  assign user_in = (TOT_W'(base_r) + TOT_W'(used_r) + HDR_SIZE + TOT_W'(mask_in))
                   & ~TOT_W'(mask_in);

  // Second half: used + span equals user - base + size.
  assign eff_cap  = (TOT_W'(cap_r) < REGION_SIZE) ? TOT_W'(cap_r) : REGION_SIZE;
  assign tot      = user_r - TOT_W'(base_r) + TOT_W'(size_r);
  assign no_space = (tot > eff_cap) || (user_r[TOT_W-1:ADDR_W] != '0);

  // Top entry is read on every accepted beat; only free looks at it.
  asa_stack_mem #(
    .DEPTH (MAX_ALLOCS),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (done_go && push),
    .wr_idx  (IDX_W'(count_r)),
    .wr_data ({HOFF_W'(used_r), user_r[ADDR_W-1:0]}),
    .rd_en   (in_acc),
    .rd_idx  (IDX_W'(count_r - CNT_W'(1))),
    .rd_data (rd_data)
  );

  assign top_hoff = rd_data[ENT_W-1:ADDR_W];
  assign top_addr = rd_data[ADDR_W-1:0];

  // Command decision. Full is checked before space; null before empty.
  always_comb begin
    dec_status = ST_OK;
    dec_addr   = '0;
    push       = 1'b0;
    pop        = 1'b0;
    used_nxt   = used_r;
    count_nxt  = count_r;
    case (cmd_r)
      CMD_ALLOC: begin
        if (count_r == MAX_CNT) begin
          dec_status = ST_FULL;
        end else if (no_space) begin
          dec_status = ST_NO_SPACE;
        end else begin
          push      = 1'b1;
          dec_addr  = user_r[ADDR_W-1:0];
          used_nxt  = SIZE_W'(tot);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_FREE: begin
        if (free_r == '0) begin
          dec_status = ST_NULL;
        end else if (count_r == '0) begin
          dec_status = ST_EMPTY;
        end else if (top_addr != free_r) begin
          dec_status = ST_NOT_TOP;
        end else begin
          pop       = 1'b1;
          used_nxt  = SIZE_W'(top_hoff);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_RESET: begin
        used_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
        // unused code: no effect, status ok
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      cap_r       <= CAPACITY_RESET;
      used_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.data.index)
          CFG_BASE:     base_r <= cfg_ch.data.value;
          CFG_CAPACITY: cap_r  <= cfg_ch.data.value[SIZE_W-1:0];
          default:      ;
        endcase
      end
      // drained with no new result behind it
      if (out_valid_r && out_ch.ready && !done_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_go) begin
            used_r      <= used_nxt;
            count_r     <= count_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_ch.data.cmd;
      size_r <= in_ch.data.request_size;
      free_r <= in_ch.data.free_address;
      user_r <= user_in;
    end
    if (done_go) begin
      out_r.status       <= dec_status;
      out_r.user_address <= dec_addr;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("stack depth above MAX_ALLOCS");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (done_go && push) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not grow the stack by one");

  a_pop_rolls_back: assert property (@(posedge clk) disable iff (!rst_n)
    (done_go && pop) |-> (SIZE_W'(top_hoff) <= used_r))
    else $error("popped header offset beyond used count");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    done_go |=> out_valid_r)
    else $error("finished command left no result beat");
`endif

endmodule

/* hw/rtl/asa_stack_mem.sv */
// Stack entry memory: one write port, one registered read port.
// Standalone; sized by the allocator top level.
module asa_stack_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 52
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_idx,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_idx,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

/* tb/tb.sv */
// Self-checking bench for aligned_stack_allocator: directed table, then random
// command streams over several region settings, checked beat by beat.
// Depends on asa_pkg (hw/rtl/asa_pkg.sv) and asa_stream_if (hw/rtl/asa_stream_if.sv).
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asa_pkg::*;

  localparam int unsigned MAX_ALLOCS   = 64;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned REGION_BITS  = 20;
  localparam logic [63:0] REGION_SIZE  = 64'd1 << REGION_BITS;
  localparam int unsigned SETTLE_CYCLES = 6;   // settle margin after the last owed result
  localparam int unsigned FILL_BEATS    = 70;  // enough to overflow a 64-deep stack
  localparam int unsigned RANDOM_BEATS  = 165;
  localparam int unsigned NUM_PHASES    = 5;

  logic clk = 1'b0;
  logic rst_n;

  asa_stream_if #(.T(in_beat_t))  in_ch  ();
  asa_stream_if #(.T(out_beat_t)) out_ch ();
  asa_stream_if #(.T(cfg_beat_t)) cfg_ch ();

  aligned_stack_allocator #(
    .MAX_ALLOCS  (MAX_ALLOCS),
    .HEADER_BYTES(HEADER_BYTES),
    .REGION_BITS (REGION_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Allocator shadow state. Updated at the edge where a command beat is
  // accepted, so it always reflects every command the block has taken.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]      shadow_base;
  logic [SIZE_W-1:0]      shadow_cap;
  logic [SIZE_W-1:0]      shadow_used;
  logic [6:0]             shadow_depth;
  logic [REGION_BITS-1:0] shadow_hdr  [MAX_ALLOCS];
  logic [ADDR_W-1:0]      shadow_addr [MAX_ALLOCS];

  out_beat_t pending_results[$];   // results owed by the block, oldest first
  int        mismatches = 0;

  // Applies one command to the shadow stack and returns the result it owes.
  function automatic out_beat_t allocator_outcome(in_beat_t b);
    out_beat_t   o;
    logic [63:0] eff_cap, start, first, mask, user, span;
    o.status       = ST_OK;
    o.user_address = '0;
    case (b.cmd)
      CMD_ALLOC: begin
        // capacity beyond the addressable region is clipped to the region
        eff_cap = (shadow_cap < REGION_SIZE) ? 64'(shadow_cap) : REGION_SIZE;
        start   = 64'(shadow_base) + 64'(shadow_used);
        first   = start + HEADER_BYTES;
        mask    = (64'd1 << b.align_log2) - 64'd1;
        user    = (first + mask) & ~mask;
        span    = (user - start) + 64'(b.request_size);
        // full stack wins over the space check
        if (shadow_depth >= MAX_ALLOCS) begin
          o.status = ST_FULL;
        end else if (64'(shadow_used) + span > eff_cap || user > 64'hFFFF_FFFF) begin
          o.status = ST_NO_SPACE;
        end else begin
          shadow_hdr[shadow_depth]  = shadow_used[REGION_BITS-1:0];
          shadow_addr[shadow_depth] = user[ADDR_W-1:0];
          shadow_depth              = shadow_depth + 7'd1;
          shadow_used               = shadow_used + span[SIZE_W-1:0];
          o.user_address            = user[ADDR_W-1:0];
        end
      end
      CMD_FREE: begin
        // null check first, then empty, then top match
        if (b.free_address == '0) begin
          o.status = ST_NULL;
        end else if (shadow_depth == 0) begin
          o.status = ST_EMPTY;
        end else if (shadow_addr[shadow_depth-7'd1] != b.free_address) begin
          o.status = ST_NOT_TOP;
        end else begin
          shadow_used  = SIZE_W'(shadow_hdr[shadow_depth-7'd1]);
          shadow_depth = shadow_depth - 7'd1;
        end
      end
      CMD_RESET: begin
        shadow_used  = '0;
        shadow_depth = '0;
      end
      default: ;  // unused code: no effect, status ok
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Rows with known=1 carry the result typed in; the rest take
  // the shadow's answer. Stack is empty and region is 0 / 1 MiB when it runs.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_beat_t  beat;
    bit        known;
    out_beat_t typed;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic void add_row(cmd_t c, int unsigned size, int unsigned align,
                                  logic [ADDR_W-1:0] addr, bit known,
                                  status_t st, logic [ADDR_W-1:0] ua);
    stim_row_t r;
    r.beat.cmd                = c;
    r.beat.request_size       = size[SIZE_W-1:0];
    r.beat.align_log2         = align[ALIGN_W-1:0];
    r.beat.free_address       = addr;
    r.known                   = known;
    r.typed.status            = st;
    r.typed.user_address      = ua;
    directed_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Random command mix. Mostly well-formed alloc / free-top traffic so the
  // stack actually grows; the rest is null, stale, corrupted and raw frees,
  // plus the odd reset and unused code.
  // ---------------------------------------------------------------------------
  function automatic in_beat_t random_cmd();
    in_beat_t b;
    int       pick;
    b.request_size = SIZE_W'($urandom);
    b.align_log2   = ALIGN_W'($urandom);
    b.free_address = $urandom;
    pick           = $urandom_range(0, 99);
    if (pick < 52) begin
      b.cmd = CMD_ALLOC;
      case ($urandom_range(0, 19))
        0:       ;  // raw 21-bit size, usually out of space
        1, 2:    b.request_size = SIZE_W'($urandom_range(0, 20000));
        default: b.request_size = SIZE_W'($urandom_range(0, 200));
      endcase
      if ($urandom_range(0, 9) != 0) b.align_log2 = ALIGN_W'($urandom_range(0, 6));
    end else if (pick < 82) begin
      b.cmd = CMD_FREE;
      if (shadow_depth != 0) b.free_address = shadow_addr[shadow_depth-7'd1];
    end else if (pick < 94) begin
      b.cmd = CMD_FREE;
      case ($urandom_range(0, 3))
        0: b.free_address = '0;
        1: if (shadow_depth > 1)
             b.free_address = shadow_addr[$urandom_range(0, shadow_depth - 2)];
        2: if (shadow_depth != 0)
             b.free_address = shadow_addr[shadow_depth-7'd1] ^ (32'd1 << $urandom_range(0, 31));
        default: ;
      endcase
    end else if (pick < 97) begin
      b.cmd = CMD_NOP;
    end else begin
      b.cmd = CMD_RESET;
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Command sender. Valid stays high across back-to-back beats; it is only
  // dropped when a gap is taken, so it never toggles twice in one step.
  // ---------------------------------------------------------------------------
  bit tx_quiet = 1'b0;

  task automatic send_cmd(in_beat_t b, bit known, out_beat_t typed);
    int        gap;
    out_beat_t predicted;
    if ($urandom_range(0, 49) == 0) tx_quiet = ~tx_quiet;
    if (tx_quiet)                        gap = 0;
    else if ($urandom_range(0, 9) == 0)  gap = $urandom_range(8, 30);
    else                                 gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // beat taken at this edge; the shadow moves with it even for typed rows
    predicted = allocator_outcome(b);
    pending_results.push_back(known ? typed : predicted);
  endtask

  // Sender pause: nothing offered until every owed result is back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both region registers back to back; only called with the block idle.
  task automatic set_region(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] cap);
    cfg_beat_t w;
    w.index = CFG_BASE;
    w.value = base;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    shadow_base = base;
    w.index = CFG_CAPACITY;
    w.value = ADDR_W'(cap);
    cfg_ch.data <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    shadow_cap = cap;
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: checks each beat against the oldest owed result and
  // throttles ready. Short random stalls, rare long ones, quiet stretches with
  // none, and one long hold-off so the block backs up into its input.
  // ---------------------------------------------------------------------------
  out_beat_t rx_owed;
  int        results_seen = 0;
  int        rx_hold      = 0;
  bit        rx_quiet     = 1'b0;
  bit        long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing owed: status %0d addr %08h",
                 out_ch.data.status, out_ch.data.user_address);
          mismatches++;
        end else begin
          rx_owed = pending_results.pop_front();
          if (out_ch.data.status !== rx_owed.status) begin
            $error("status: expected %0d, got %0d", rx_owed.status, out_ch.data.status);
            mismatches++;
          end
          if (out_ch.data.user_address !== rx_owed.user_address) begin
            $error("user_address: expected %08h, got %08h",
                   rx_owed.user_address, out_ch.data.user_address);
            mismatches++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) rx_quiet = ~rx_quiet;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        rx_hold        = 400;
        out_ch.ready  <= 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
        rx_hold       = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_beat_t          b;
    out_beat_t         none;
    logic [ADDR_W-1:0] phase_base [NUM_PHASES];
    logic [SIZE_W-1:0] phase_cap  [NUM_PHASES];

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    none         = '0;

    // shadow matches the block's reset state
    shadow_base  = '0;
    shadow_cap   = CAPACITY_RESET;
    shadow_used  = '0;
    shadow_depth = '0;

    // phase 0 keeps the reset region; phases 1 to 3 hit the extremes, phase 4 is random
    phase_base[0] = 32'h0000_0000;  phase_cap[0] = CAPACITY_RESET;
    phase_base[1] = 32'hFFFF_F000;  phase_cap[1] = 21'h1F_FFFF;  // near top, cap clipped
    phase_base[2] = 32'h8000_0003;  phase_cap[2] = 21'd4096;     // unaligned, tight
    phase_base[3] = 32'hFFFF_FFFF;  phase_cap[3] = 21'd0;        // nothing fits
    phase_base[4] = $urandom;       phase_cap[4] = SIZE_W'($urandom_range(0, 21'h1F_FFFF));

    // null, empty, simple alloc, not top, pop, exact fit, overflow, align extremes, nop, reset
    add_row(CMD_FREE,  0,          0,  32'h0,         1, ST_NULL,     32'h0);
    add_row(CMD_FREE,  0,          0,  32'hFFFF_FFFF, 1, ST_EMPTY,    32'h0);
    add_row(CMD_ALLOC, 0,          0,  32'h0,         1, ST_OK,       32'd16);
    add_row(CMD_FREE,  0,          0,  32'd32,        1, ST_NOT_TOP,  32'h0);
    add_row(CMD_FREE,  0,          0,  32'd16,        1, ST_OK,       32'h0);
    add_row(CMD_ALLOC, 1048576,    0,  32'h0,         1, ST_NO_SPACE, 32'h0);
    add_row(CMD_ALLOC, 21'h1FFFFF, 15, 32'h0,         1, ST_NO_SPACE, 32'h0);
    add_row(CMD_ALLOC, 1048560,    0,  32'h0,         1, ST_OK,       32'd16);
    add_row(CMD_ALLOC, 0,          0,  32'h0,         1, ST_NO_SPACE, 32'h0);
    add_row(CMD_FREE,  0,          0,  32'd16,        1, ST_OK,       32'h0);
    add_row(CMD_ALLOC, 5,          15, 32'h0,         0, ST_OK,       32'h0);
    add_row(CMD_ALLOC, 100,        12, 32'h0,         0, ST_OK,       32'h0);
    add_row(CMD_ALLOC, 1,          13, 32'h0,         0, ST_OK,       32'h0);
    add_row(CMD_FREE,  0,          0,  32'd40960,     0, ST_OK,       32'h0);
    add_row(CMD_FREE,  0,          0,  32'd32768,     0, ST_OK,       32'h0);
    add_row(CMD_NOP,   21'h1FFFFF, 15, 32'hFFFF_FFFF, 1, ST_OK,       32'h0);
    add_row(CMD_RESET, 21'h1FFFFF, 15, 32'hFFFF_FFFF, 1, ST_OK,       32'h0);
    add_row(CMD_FREE,  0,          0,  32'd32768,     1, ST_EMPTY,    32'h0);
    add_row(CMD_ALLOC, 0,          4,  32'h0,         1, ST_OK,       32'd16);
    add_row(CMD_RESET, 0,          0,  32'h0,         1, ST_OK,       32'h0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].beat, directed_rows[i].known, directed_rows[i].typed);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        set_region(phase_base[p], phase_cap[p]);
      end
      // fill burst: FILL_BEATS small allocs, enough to reach full status where they fit
      for (int i = 0; i < FILL_BEATS; i++) begin
        b              = random_cmd();
        b.cmd          = CMD_ALLOC;
        b.request_size = SIZE_W'($urandom_range(0, 64));
        b.align_log2   = ALIGN_W'($urandom_range(0, 4));
        send_cmd(b, 1'b0, none);
      end
      for (int i = 0; i < RANDOM_BEATS; i++) begin
        // in phase 0, one sender pause mid-stream until everything owed is back
        if (p == 0 && i == 80) wait_idle();
        send_cmd(random_cmd(), 1'b0, none);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (~1200 beats with worst gaps).
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/asa_pkg.sv
hw/rtl/asa_stream_if.sv
hw/rtl/asa_stack_mem.sv
hw/rtl/aligned_stack_allocator.sv
tb/tb.sv
